// File: hdl/tsp_pkg.sv
// Shared constants, codes and types of the tagged slot pool.
`default_nettype none
package tsp_pkg;

    // Pool geometry.
    localparam int SLOTS     = 64;
    localparam int KIND_BITS = 8;
    localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    // Fixed field widths on the stream ports.
    localparam int OP_W     = 3;
    localparam int KIND_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Request opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_FIND  = 3'd2,
        OP_FIRST = 3'd3,
        OP_NEXT  = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } state_t;

    // What a cell tests during evaluation.
    typedef enum logic [1:0] {
        M_FREE_SLOT,
        M_OCCUPIED,
        M_LIVE,
        M_MATCH
    } match_mode_t;

    // What a selected cell does at commit.
    typedef enum logic [1:0] {
        A_NONE,
        A_SET,
        A_CLEAR
    } action_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                 eval;
        logic                 commit;
        match_mode_t          mode;
        action_t              act;
        logic [KIND_BITS-1:0] kind;
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: hdl/tsp_cell.sv
// One slot of the pool: its tag, its active flag and its registered hit.
`default_nettype none
module tsp_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire tsp_pkg::cell_cmd_t cmd,
    input  wire                  window,
    input  wire                  prior_in,
    output logic                 prior_out,
    output logic                 sel
);
    import tsp_pkg::*;

    logic [KIND_BITS-1:0] kind_reg;
    logic                 active_reg;
    logic                 hit_reg;
    logic                 hit_next;

    // Local test of this slot against the broadcast request.
    always_comb begin
        case (cmd.mode)
            M_FREE_SLOT: hit_next = (kind_reg == '0);
            M_OCCUPIED:  hit_next = (kind_reg != '0);
            M_LIVE:      hit_next = (kind_reg != '0) && active_reg;
            M_MATCH:     hit_next = (kind_reg == cmd.kind) && active_reg;
            default:     hit_next = 1'b0;
        endcase
        hit_next = hit_next && window;
    end

    // The lowest hit wins: a hit further down the chain blocks this one.
    assign sel       = hit_reg && !prior_in;
    assign prior_out = hit_reg || prior_in;

    // Slot storage and hit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= '0;
            active_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            if (cmd.eval) begin
                hit_reg <= hit_next;
            end
            if (cmd.commit && sel) begin
                if (cmd.act == A_SET) begin
                    kind_reg   <= cmd.kind;
                    active_reg <= 1'b1;
                end else if (cmd.act == A_CLEAR) begin
                    kind_reg   <= '0;
                    active_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/tsp_cell_row.sv
// The row of slot cells, chained so that the lowest hit is selected.
`default_nettype none
module tsp_cell_row (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire tsp_pkg::cell_cmd_t      cmd,
    input  wire [tsp_pkg::SLOTS-1:0]     window,
    output wire [tsp_pkg::SLOTS-1:0]     sel,
    output logic                         any_hit
);
    import tsp_pkg::*;

    wire [SLOTS:0] chain;

    assign chain[0] = 1'b0;

    // Each cell passes the "hit seen below" flag to its upper neighbour.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tsp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .window    (window[g]),
            .prior_in  (chain[g]),
            .prior_out (chain[g+1]),
            .sel       (sel[g])
        );
    end

    assign any_hit = chain[SLOTS];

endmodule
`default_nettype wire

// File: hdl/tagged_slot_pool.sv
// Top level of the tagged slot pool: request sequencer, counters and result register.
//
//   Channel  Direction  Beat contents (tdata, lowest bit first)
//   s_       in         opcode[2:0], kind[10:3], slot_index[16:11], zero pad to 24
//   m_       out        status[1:0], slot[7:2], live_count[14:8], high_mark[21:15], pad
//
// Each request passes the states S_IDLE, which accepts the beat, S_EVAL, in which every
// cell tests its slot and registers a hit, and S_COMMIT, in which the cell chain picks
// the lowest hit, the chosen cell is written and the result enters the output register.
// A new beat is taken while the previous result still waits on m_tready; the commit
// cycle holds until the output register is free. Reset clears every slot at once.
`default_nettype none
module tagged_slot_pool (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // opcode[2:0], kind[10:3], slot_index[16:11], zero [23:17]
    input  wire  [23:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // status[1:0], slot[7:2], live_count[14:8], high_mark[21:15], zero [23:22]
    output logic [23:0] m_tdata
);
    import tsp_pkg::*;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg;
    logic [KIND_BITS-1:0] kind_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [CNT_BITS-1:0]  used_reg, used_next;
    logic [CNT_BITS-1:0]  hwm_reg, hwm_next;
    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg, m_tdata_next;

    cell_cmd_t            cmd;
    logic [SLOTS-1:0]     window;
    logic [SLOTS-1:0]     sel_vec;
    logic                 any_hit;
    logic [IDX_BITS-1:0]  sel_idx;
    logic                 idx_ok;
    logic                 bad_req;
    logic                 commit_fire;
    status_t              status;
    logic [INDEX_W-1:0]   slot_out;

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Requests that are refused before any slot is looked at.
    assign idx_ok = (32'(idx_reg) < 32'(SLOTS));
    always_comb begin
        case (op_reg)
            OP_ALLOC:         bad_req = (kind_reg == '0);
            OP_FREE, OP_FIND,
            OP_NEXT:          bad_req = !idx_ok;
            OP_FIRST:         bad_req = 1'b0;
            default:          bad_req = 1'b1;
        endcase
    end

    // Per-slot window: the single addressed slot, every slot for an allocation, or the search range below the mark.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            case (op_reg)
                OP_ALLOC:         window[i] = 1'b1;
                OP_FREE, OP_FIND: window[i] = (32'(i) == 32'(idx_reg));
                OP_FIRST:         window[i] = (32'(i) < 32'(hwm_reg));
                OP_NEXT:          window[i] = (32'(i) > 32'(idx_reg))
                                              && (32'(i) < 32'(hwm_reg));
                default:          window[i] = 1'b0;
            endcase
        end
    end

    // Cell command and next state.
    always_comb begin
        state_next  = state_reg;
        commit_fire = 1'b0;
        cmd.eval    = 1'b0;
        cmd.kind    = kind_reg;
        case (op_reg)
            OP_ALLOC: begin
                cmd.mode = M_FREE_SLOT;
                cmd.act  = A_SET;
            end
            OP_FREE: begin
                cmd.mode = M_OCCUPIED;
                cmd.act  = A_CLEAR;
            end
            OP_FIND: begin
                cmd.mode = M_LIVE;
                cmd.act  = A_NONE;
            end
            default: begin
                cmd.mode = M_MATCH;
                cmd.act  = A_NONE;
            end
        endcase
        if (bad_req) begin
            cmd.act = A_NONE;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    commit_fire = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.commit = commit_fire;
    end

    tsp_cell_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .window  (window),
        .sel     (sel_vec),
        .any_hit (any_hit)
    );

    // Encode the one-hot selection into a slot number.
    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (sel_vec[i]) begin
                sel_idx = sel_idx | IDX_BITS'(i);
            end
        end
    end

    // Result status and counter updates.
    always_comb begin
        used_next = used_reg;
        hwm_next  = hwm_reg;
        if (bad_req) begin
            status = ST_BAD;
        end else if (any_hit) begin
            status = ST_OK;
        end else if (op_reg == OP_FREE) begin
            status = ST_BAD;
        end else begin
            status = ST_MISS;
        end
        if (status == ST_OK && op_reg == OP_ALLOC) begin
            used_next = used_reg + 1'b1;
            if ((CNT_BITS'(sel_idx) + 1'b1) > hwm_reg) begin
                hwm_next = CNT_BITS'(sel_idx) + 1'b1;
            end
        end else if (status == ST_OK && op_reg == OP_FREE && used_reg != '0) begin
            used_next = used_reg - 1'b1;
        end
        slot_out     = (status == ST_OK) ? INDEX_W'(sel_idx) : '0;
        m_tdata_next = {2'b00, COUNT_W'(hwm_next), COUNT_W'(used_next), slot_out, status};
    end

    // Sequencer, request capture, counters and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            hwm_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit_fire) begin
                used_reg     <= used_next;
                hwm_reg      <= hwm_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tdata[2:0];
            kind_reg <= KIND_BITS'(s_tdata[10:3]);
            idx_reg  <= s_tdata[16:11];
        end
        if (commit_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // The cell chain never selects more than one slot.
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one slot selected");

    // The live count never exceeds the high-water mark.
    a_count_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= hwm_reg)
        else $error("live count above high-water mark");

    // A new result appears only from a commit cycle.
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_COMMIT))
        else $error("result without commit");

    // The high-water mark never falls.
    a_mark_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> hwm_reg >= $past(hwm_reg))
        else $error("high-water mark decreased");

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of the tagged slot pool: directed and random requests, predicted results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp_pkg::*;

    // Opcodes outside the defined set, answered as invalid.
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] idx;
    } pool_req_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  slot;
        logic [COUNT_W-1:0]  live;
        logic [COUNT_W-1:0]  mark;
    } pool_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // opcode[2:0], kind[10:3], slot_index[16:11], zero [23:17]
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[1:0], slot[7:2], live_count[14:8], high_mark[21:15], zero [23:22]
    logic [23:0] m_tdata;

    tagged_slot_pool DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the pool, in its reset state.
    logic [KIND_BITS-1:0] shadow_tag [SLOTS];
    logic                 shadow_act [SLOTS];
    logic [COUNT_W-1:0]   shadow_live = '0;
    logic [COUNT_W-1:0]   shadow_mark = '0;

    pool_req_t    pending_reqs[$];
    pool_result_t pending_results[$];

    int  errors      = 0;
    int  n_requests  = 0;
    int  n_results   = 0;
    int  n_full      = 0;
    int  peak_live   = 0;
    int  idle_cycles = 0;
    int  send_gap    = 0;
    int  send_burst  = 0;
    int  ready_left  = 0;
    bit  stim_done   = 1'b0;
    logic req_taken  = 1'b0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_tag[i] = '0;
            shadow_act[i] = 1'b0;
        end
    end

    // Lowest active slot of the given type from start up to the high-water mark, or -1.
    function automatic int search_kind(input int start, input logic [KIND_BITS-1:0] kind);
        int hit;
        hit = -1;
        for (int i = start; i < int'(shadow_mark) && i < SLOTS; i++) begin
            if (hit < 0 && shadow_tag[i] == kind && shadow_act[i])
                hit = i;
        end
        return hit;
    endfunction

    // Apply one request to the shadow pool and return the answer it should produce.
    function automatic pool_result_t serve_request(input pool_req_t r);
        pool_result_t res;
        int           hit;
        res.status = ST_BAD;
        res.slot   = '0;
        hit        = -1;
        case (r.op)
            OP_ALLOC: begin
                if (r.kind != '0) begin
                    res.status = ST_MISS;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && shadow_tag[i] == '0)
                            hit = i;
                    end
                    if (hit >= 0) begin
                        shadow_tag[hit] = r.kind;
                        shadow_act[hit] = 1'b1;
                        shadow_live     = shadow_live + 1'b1;
                        if (hit >= int'(shadow_mark))
                            shadow_mark = COUNT_W'(hit + 1);
                        res.status = ST_OK;
                        res.slot   = INDEX_W'(hit);
                    end else begin
                        n_full++;
                    end
                end
            end
            OP_FREE: begin
                if (int'(r.idx) < SLOTS && shadow_tag[r.idx] != '0) begin
                    shadow_tag[r.idx] = '0;
                    shadow_act[r.idx] = 1'b0;
                    // The count saturates at zero.
                    if (shadow_live != '0)
                        shadow_live = shadow_live - 1'b1;
                    res.status = ST_OK;
                    res.slot   = r.idx;
                end
            end
            OP_FIND: begin
                if (int'(r.idx) < SLOTS) begin
                    if (shadow_tag[r.idx] != '0 && shadow_act[r.idx]) begin
                        res.status = ST_OK;
                        res.slot   = r.idx;
                    end else begin
                        res.status = ST_MISS;
                    end
                end
            end
            OP_FIRST, OP_NEXT: begin
                if (r.op == OP_FIRST || int'(r.idx) < SLOTS) begin
                    hit = search_kind((r.op == OP_FIRST) ? 0 : int'(r.idx) + 1, r.kind);
                    res.status = (hit >= 0) ? ST_OK : ST_MISS;
                    if (hit >= 0)
                        res.slot = INDEX_W'(hit);
                end
            end
            default: res.status = ST_BAD;
        endcase
        if (int'(shadow_live) > peak_live)
            peak_live = int'(shadow_live);
        res.live = shadow_live;
        res.mark = shadow_mark;
        return res;
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input int kind, input int idx);
        pool_req_t r;
        r.op   = op;
        r.kind = KIND_W'(kind);
        r.idx  = INDEX_W'(idx);
        pending_reqs.push_back(r);
    endtask

    // Tags are drawn mostly from a few common types so that searches find matches.
    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r <= 5)
            return (r == 5) ? 255 : r;
        else
            return $urandom_range(0, 255);
    endfunction

    // A phase of random requests with the given share of allocations and frees.
    task automatic add_random(input int n, input int alloc_pct, input int free_pct);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                add_req(OP_ALLOC, pick_kind(), $urandom_range(0, 63));
            else if (r < alloc_pct + free_pct)
                add_req(OP_FREE, pick_kind(), $urandom_range(0, 63));
            else if ($urandom_range(0, 99) < 4)
                add_req(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), pick_kind(),
                        $urandom_range(0, 63));
            else begin
                case ($urandom_range(0, 2))
                    0:       add_req(OP_FIND,  pick_kind(), $urandom_range(0, 63));
                    1:       add_req(OP_FIRST, pick_kind(), $urandom_range(0, 63));
                    default: add_req(OP_NEXT,  pick_kind(), $urandom_range(0, 63));
                endcase
            end
        end
    endtask

    // Stimulus: directed corner cases, starting from the empty pool, then random phases.
    initial begin
        // Empty pool: every lookup misses and the empty slot cannot be freed.
        add_req(OP_FIND,  0,   0);
        add_req(OP_FIRST, 5,   0);
        add_req(OP_FREE,  0,   0);
        add_req(OP_ALLOC, 0,   0);
        // Fill the bottom slots, including the widest tag.
        add_req(OP_ALLOC, 255, 63);
        add_req(OP_ALLOC, 1,   0);
        add_req(OP_ALLOC, 5,   0);
        add_req(OP_ALLOC, 5,   0);
        add_req(OP_FIND,  0,   63);
        add_req(OP_FIRST, 5,   0);
        add_req(OP_NEXT,  5,   2);
        add_req(OP_NEXT,  5,   3);
        // Searching from above the high-water mark finds nothing.
        add_req(OP_NEXT,  5,   63);
        add_req(OP_NEXT,  255, 10);
        // Free, then free the same slot again, then reuse the hole.
        add_req(OP_FREE,  0,   1);
        add_req(OP_FREE,  0,   1);
        add_req(OP_FIND,  0,   1);
        add_req(OP_ALLOC, 7,   0);
        add_req(OP_FIRST, 7,   0);
        add_req(OP_FIND,  0,   0);
        // Opcodes without a meaning.
        add_req(3'd5, 5, 2);
        add_req(3'd6, 255, 63);
        add_req(3'd7, 0, 0);
        // Random phases: fill past full, drain, mixed, fill again.
        add_random(200, 65, 10);
        add_random(200, 10, 60);
        add_random(200, 35, 30);
        add_random(200, 65, 10);
    end

    // Reset, held low from the start and released between edges.
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        if (r < 5) begin
            send_burst = $urandom_range(40, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Request driver: presents one beat at a time from the pending queue.
    always @(negedge aclk) begin : request_driver
        pool_req_t r;
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (s_tvalid)
                send_gap = pick_send_gap();
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_tdata  <= {7'b0, r.idx, r.kind, r.op};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid  <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // Result back-pressure: ready stretches, short stalls, a few long stalls.
    always @(negedge aclk) begin : ready_driver
        int r;
        if (aresetn) begin
            if (ready_left > 0) begin
                ready_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    m_tready   <= 1'b1;
                    ready_left = $urandom_range(50, 150);
                end else if (r < 60) begin
                    m_tready   <= 1'b1;
                    ready_left = $urandom_range(0, 7);
                end else if (r < 93) begin
                    m_tready   <= 1'b0;
                    ready_left = $urandom_range(0, 2);
                end else begin
                    m_tready   <= 1'b0;
                    ready_left = $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor: checks each result beat against the oldest prediction, then predicts
    // the request accepted at this edge.
    always @(posedge aclk) begin : result_monitor
        pool_result_t want;
        pool_req_t    r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status",     int'(want.status), int'(m_tdata[1:0]));
                    check_field("slot",       int'(want.slot),   int'(m_tdata[7:2]));
                    check_field("live_count", int'(want.live),   int'(m_tdata[14:8]));
                    check_field("high_mark",  int'(want.mark),   int'(m_tdata[21:15]));
                end
            end
            if (s_tvalid && s_tready) begin
                r.op   = s_tdata[2:0];
                r.kind = s_tdata[10:3];
                r.idx  = s_tdata[16:11];
                n_requests++;
                pending_results.push_back(serve_request(r));
            end
        end
        req_taken <= aresetn && s_tvalid && s_tready;
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("tagged_slot_pool regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // End of run: drain all predictions, let the pipeline settle, report.
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Run covered %0d requests and %0d results, %0d full-pool answers,",
                 n_requests, n_results, n_full);
        $display("peak occupancy %0d of %0d slots, %0d mismatches.", peak_live, SLOTS, errors);
        if (errors == 0)
            $display("tagged_slot_pool regression: pass");
        else
            $display("tagged_slot_pool regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/tsp_pkg.sv
hdl/tsp_cell.sv
hdl/tsp_cell_row.sv
hdl/tagged_slot_pool.sv
test/testbench.sv
